FILE: rtl/pedr_pkg.sv
// ----------------------------------------------------------------------------
// pedr_pkg
// Types, constants and rounding helpers for the polynomial / design row unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pedr_pkg;

	localparam int MAX_TERMS = 7;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int TERM_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int RND_W     = PROD_W - FRAC_BITS;
	localparam int SUM_W     = RND_W + 3;
	localparam int DIFF_W    = SUM_W + 1;
	localparam int IN_W      = 2 * DATA_W;
	localparam int OUT_RAW_W = TERM_W + 3 * DATA_W;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	typedef logic signed [DATA_W-1:0] q_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [RND_W-1:0]  rnd_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic [TERM_W-1:0]        term_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_TERMS = 3'd0,
		REG_COEF_0    = 3'd1,
		REG_COEF_1    = 3'd2,
		REG_COEF_2    = 3'd3,
		REG_COEF_3    = 3'd4,
		REG_COEF_4    = 3'd5,
		REG_COEF_5    = 3'd6,
		REG_COEF_6    = 3'd7
	} reg_idx_t;

	localparam q_t    Q_ONE  = q_t'(1 << FRAC_BITS);
	localparam prod_t HALF   = prod_t'(1) <<< (FRAC_BITS - 1);
	localparam diff_t Q_MAX  = diff_t'($signed({1'b0, {(DATA_W-1){1'b1}}}));
	localparam diff_t Q_MIN  = diff_t'($signed({1'b1, {(DATA_W-1){1'b0}}}));
	localparam term_t IDX_LAST = term_t'(MAX_TERMS - 1);

	// payload moving from cell to cell
	typedef struct packed {
		q_t                    x;
		q_t                    meas;
		sum_t                  sum;
		q_t [MAX_TERMS-1:0]    pw;
	} link_t;

	// round half up, then drop fraction bits
	function automatic rnd_t rnd(prod_t v);
		prod_t t;
		t = (v + HALF) >>> FRAC_BITS;
		return t[RND_W-1:0];
	endfunction

	function automatic q_t sat(diff_t v);
		diff_t t;
		t = v;
		if (v > Q_MAX) begin
			t = Q_MAX;
		end else if (v < Q_MIN) begin
			t = Q_MIN;
		end
		return t[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pedr_cell.sv
// ----------------------------------------------------------------------------
// pedr_cell
// One term of the chain: multiplies the incoming power by x and by its
// coefficient, then rounds, saturates the next power and accumulates the term.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pedr_cell import pedr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire term_t idx,
	input  wire logic  use_term,
	input  wire q_t    coef,
	input  wire logic  in_valid,
	input  wire link_t in_link,
	output logic       out_valid,
	output link_t      out_link
);

	logic  valid_s1;
	link_t link_s1;
	prod_t prod_p_s1;
	prod_t prod_c_s1;
	q_t    p_in;
	link_t link_nxt;

	assign p_in = in_link.pw[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			link_s1   <= in_link;
			prod_p_s1 <= prod_t'(p_in) * prod_t'(in_link.x);
			prod_c_s1 <= use_term ? prod_t'(coef) * prod_t'(p_in) : '0;
		end
	end

	always_comb begin
		link_nxt     = link_s1;
		link_nxt.sum = link_s1.sum + sum_t'(rnd(prod_c_s1));
		if (idx != IDX_LAST) begin
			link_nxt.pw[idx + term_t'(1)] = sat(diff_t'(rnd(prod_p_s1)));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_link <= link_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pedr_out.sv
// ----------------------------------------------------------------------------
// pedr_out
// Result stage: takes one finished sample off the chain and sends its design
// row beat by beat, with value and residual on the last beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pedr_out import pedr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire link_t             in_link,
	input  wire term_t             n_eff,
	output logic                   en,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// term_index, power, poly_value, residual, zero pad
	output logic [OUT_W-1:0]       m_tdata,
	output logic                   m_tlast
);

	logic               busy_q;
	term_t              cnt_q;
	q_t [MAX_TERMS-1:0] pw_q;
	q_t                 poly_q;
	q_t                 res_q;
	logic               free;
	logic               load;
	logic               beat;
	q_t                 poly_o;
	q_t                 res_o;

	assign m_tvalid = busy_q;
	assign m_tlast  = (cnt_q == n_eff - term_t'(1));
	assign beat     = m_tvalid && m_tready;
	assign free     = !busy_q || (beat && m_tlast);
	assign load     = in_valid && free;
	assign en       = !in_valid || free;

	assign poly_o  = m_tlast ? poly_q : '0;
	assign res_o   = m_tlast ? res_q : '0;
	assign m_tdata = OUT_W'({res_o, poly_o, pw_q[cnt_q], cnt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (beat) begin
			if (m_tlast) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + term_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pw_q   <= in_link.pw;
			poly_q <= sat(diff_t'(in_link.sum));
			res_q  <= sat(diff_t'(in_link.meas) - diff_t'(in_link.sum));
		end
	end

endmodule

`default_nettype wire

FILE: rtl/polynomial_eval_with_design_row_unit.sv
// ----------------------------------------------------------------------------
// polynomial_eval_with_design_row_unit
// Polynomial value, residual and design matrix row per sample, signed Q16.16.
// ----------------------------------------------------------------------------
// Input beat on s_*: sample_x and measured. For each sample the block sends
// num_terms beats on m_* (num_terms of zero acts as one): term index k and
// x^k, and on the tlast beat the saturated polynomial value and the residual
// measured minus value (other beats carry zero there).
// The user writes coefficients and num_terms on cfg_* (index 0: num_terms,
// 1..7: coef_0..coef_6) only while the block is idle; the block itself does
// not enforce this: cfg_ready is always high. Structure: a chain of seven
// cells, two register stages each, then the result stage. Throughput: one
// result beat per cycle while the receiver is ready; samples enter the chain
// back to back until s_tready drops. When the receiver stalls, the result
// stage holds; once a finished sample waits at the chain end, the whole
// chain freezes and s_tready drops. Reset clears all valid flags, sets
// num_terms to 1 and coefficients to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polynomial_eval_with_design_row_unit import pedr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// sample_x, measured
	input  wire logic [IN_W-1:0]      s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// term_index, power, poly_value, residual, zero pad
	output logic [OUT_W-1:0]          m_tdata,
	output logic                      m_tlast,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data
);

	term_t              num_terms_q;
	q_t [MAX_TERMS-1:0] coef_q;
	term_t              n_eff;
	logic [MAX_TERMS-1:0] use_term;
	logic               en;
	logic [MAX_TERMS:0] valid_c;
	link_t [MAX_TERMS:0] link_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_terms_q <= term_t'(1);
			coef_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_NUM_TERMS: num_terms_q <= cfg_data[TERM_W-1:0];
				default:       coef_q[cfg_index - CFG_IDX_W'(REG_COEF_0)] <= cfg_data;
			endcase
		end
	end

	always_comb begin
		n_eff = num_terms_q;
		if (num_terms_q == '0) begin
			n_eff = term_t'(1);
		end else if (num_terms_q > term_t'(MAX_TERMS)) begin
			n_eff = term_t'(MAX_TERMS);
		end
	end

	assign s_tready = en;

	always_comb begin
		link_c[0]      = '0;
		link_c[0].x    = s_tdata[DATA_W-1:0];
		link_c[0].meas = s_tdata[IN_W-1:DATA_W];
		link_c[0].pw[0] = Q_ONE;
	end
	assign valid_c[0] = s_tvalid;

	for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
		assign use_term[k] = (term_t'(k) < n_eff);

		pedr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.idx       (term_t'(k)),
			.use_term  (use_term[k]),
			.coef      (coef_q[k]),
			.in_valid  (valid_c[k]),
			.in_link   (link_c[k]),
			.out_valid (valid_c[k+1]),
			.out_link  (link_c[k+1])
		);
	end

	pedr_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c[MAX_TERMS]),
		.in_link  (link_c[MAX_TERMS]),
		.n_eff    (n_eff),
		.en       (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

FILE: tb/tb_polynomial_eval_with_design_row_unit.sv
// ----------------------------------------------------------------------------
// tb_polynomial_eval_with_design_row_unit
// Self-checking bench for the polynomial value / design matrix row unit.
// ----------------------------------------------------------------------------
// A short table of directed samples and register writes covers the field
// extremes, saturation, zero num_terms and half-up rounding. Ten random phases
// follow, each with a fresh coefficient set. Every accepted sample is run
// through a Q16.16 model in the bench and yields the expected result beats.
// Each result beat is checked field by field in order. The sender runs in
// bursts, and the receiver stalls on its own pattern. One phase holds the
// receiver off long enough to back the block up, and one has the sender wait
// until the block has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_polynomial_eval_with_design_row_unit;
	import pedr_pkg::*;

	localparam int LIMIT       = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam q_t QMAX        = 32'sh7FFF_FFFF;
	localparam q_t QMIN        = 32'sh8000_0000;

	typedef struct {
		term_t idx;
		q_t    power;
		q_t    poly;
		q_t    resid;
		logic  last;
	} drow_t;

	typedef struct {
		logic        is_cfg;
		reg_idx_t    addr;
		logic [31:0] a;
		logic [31:0] b;
		logic        known;
		q_t          poly;
		q_t          resid;
	} step_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;

	drow_t design_rows[$];
	term_t nterm_cfg = term_t'(1);
	q_t    coef_cfg[MAX_TERMS] = '{default: '0};
	int    err_cnt = 0;
	int    cycles = 0;
	int    burst_left = 0;
	bit    gaps_on = 1'b1;
	bit    hold_off_req = 1'b0;

	polynomial_eval_with_design_row_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint round_q(longint v);
		return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic longint clamp_q(longint v);
		if (v > longint'(QMAX))
			return longint'(QMAX);
		if (v < longint'(QMIN))
			return longint'(QMIN);
		return v;
	endfunction

	// expected beats for one sample; returns the last one, queues all if commit
	function automatic drow_t eval_row_set(q_t x, q_t meas, bit commit);
		longint pw, acc, xw;
		int     n, k;
		drow_t  r;
		xw  = longint'(x);
		pw  = longint'(1) <<< FRAC_BITS;
		acc = 0;
		n   = int'(nterm_cfg);
		if (n < 1)
			n = 1;
		if (n > MAX_TERMS)
			n = MAX_TERMS;
		for (k = 0; k < n; k++) begin
			if (k > 0)
				pw = clamp_q(round_q(pw * xw));
			acc += round_q(longint'(coef_cfg[k]) * pw);
			r.idx   = term_t'(k);
			r.power = q_t'(pw);
			r.poly  = '0;
			r.resid = '0;
			r.last  = 1'b0;
			if (k == n - 1) begin
				r.poly  = q_t'(clamp_q(acc));
				r.resid = q_t'(clamp_q(longint'(meas) - acc));
				r.last  = 1'b1;
			end
			if (commit)
				design_rows.push_back(r);
		end
		return r;
	endfunction

	function automatic q_t rand_q();
		q_t v;
		case ($urandom_range(0, 9))
			0: v = QMAX;
			1: v = QMIN;
			2: v = '0;
			3, 4: v = $urandom;
			default: begin
				v = $urandom_range(0, 32'h0002_0000);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	function automatic step_t mk_cfg(reg_idx_t addr, logic [31:0] d);
		step_t s;
		s = '{is_cfg: 1'b1, addr: addr, a: d, b: '0, known: 1'b0, poly: '0, resid: '0};
		return s;
	endfunction

	function automatic step_t mk_smp(logic [31:0] x, logic [31:0] meas, logic known,
			q_t poly, q_t resid);
		step_t s;
		s = '{is_cfg: 1'b0, addr: REG_NUM_TERMS, a: x, b: meas, known: known,
			poly: poly, resid: resid};
		return s;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	task automatic send_sample(q_t x, q_t meas);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {meas, x};
		do @(posedge clk); while (!s_tready);
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// stop offering and wait for every expected beat
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (design_rows.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t addr, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= addr;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		if (addr == REG_NUM_TERMS)
			nterm_cfg = d[TERM_W-1:0];
		else
			coef_cfg[int'(addr) - 1] = d;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// beat monitor and scoreboard
	always @(posedge clk) begin : mon
		drow_t e;
		cycles++;
		if (cycles > LIMIT) begin
			$display("[polynomial_eval_with_design_row_unit] ERROR");
			$finish;
		end
		if (s_tvalid && s_tready)
			void'(eval_row_set(s_tdata[DATA_W-1:0], s_tdata[IN_W-1:DATA_W], 1'b1));
		if (m_tvalid && m_tready) begin
			if (design_rows.size() == 0) begin
				$display("%0t: result beat with nothing expected: expected none got %h",
					$time, m_tdata);
				err_cnt++;
			end else begin
				e = design_rows.pop_front();
				check_field("term_index", 32'(e.idx), 32'(m_tdata[TERM_W-1:0]));
				check_field("power", e.power, m_tdata[TERM_W +: DATA_W]);
				check_field("poly_value", e.poly, m_tdata[TERM_W + DATA_W +: DATA_W]);
				check_field("residual", e.resid, m_tdata[TERM_W + 2*DATA_W +: DATA_W]);
				check_field("last", 32'(e.last), 32'(m_tlast));
			end
		end
	end

	// receiver: random stall modes, plus one long hold-off
	initial begin : rx
		int       left;
		rx_mode_t mode;
		left = 0;
		mode = RX_OPEN;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(16, 96);
				end
				left--;
				case (mode)
					RX_OPEN:     m_tready <= 1'b1;
					RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   m_tready <= ($urandom_range(0, 9) == 0);
					RX_PERIODIC: m_tready <= ((left % 5) >= 2);
					default:     m_tready <= 1'b1;
				endcase
			end
		end
	end

	initial begin : stim
		step_t tab[$];
		drow_t r;
		int    i, j, ph, nt;

		// power-on settings: one term, all coefficients zero
		tab.push_back(mk_smp(32'h0, 32'h0, 1'b1, '0, '0));
		tab.push_back(mk_smp(QMAX, QMAX, 1'b1, '0, QMAX));
		tab.push_back(mk_smp(QMIN, QMIN, 1'b1, '0, QMIN));
		tab.push_back(mk_smp(32'h5555_AAAA, 32'hAAAA_5555, 1'b1, '0, 32'hAAAA_5555));
		// seven terms of 1.0; upper data bits ignored for num_terms
		tab.push_back(mk_cfg(REG_NUM_TERMS, 32'hFFFF_FFFF));
		for (i = 0; i < MAX_TERMS; i++)
			tab.push_back(mk_cfg(reg_idx_t'(int'(REG_COEF_0) + i), Q_ONE));
		tab.push_back(mk_smp(Q_ONE, 32'h0, 1'b1, 32'h0007_0000, 32'hFFF9_0000));
		tab.push_back(mk_smp(32'h0, Q_ONE, 1'b1, Q_ONE, '0));
		tab.push_back(mk_smp(32'hFFFF_0000, 32'h0, 1'b1, Q_ONE, 32'hFFFF_0000));
		tab.push_back(mk_smp(QMAX, QMIN, 1'b0, '0, '0));
		tab.push_back(mk_smp(QMIN, QMAX, 1'b0, '0, '0));
		// full-scale coefficients: sum overflows and saturates
		for (i = 0; i < MAX_TERMS; i++)
			tab.push_back(mk_cfg(reg_idx_t'(int'(REG_COEF_0) + i), QMAX));
		tab.push_back(mk_smp(QMAX, QMIN, 1'b1, QMAX, QMIN));
		tab.push_back(mk_smp(QMIN, QMAX, 1'b0, '0, '0));
		// num_terms of zero acts as one
		tab.push_back(mk_cfg(REG_NUM_TERMS, 32'h0000_0008));
		tab.push_back(mk_cfg(REG_COEF_0, QMIN));
		tab.push_back(mk_smp(QMAX, QMAX, 1'b1, QMIN, QMAX));
		tab.push_back(mk_smp(QMIN, QMIN, 1'b1, QMIN, '0));
		// rounding of products, half goes up
		tab.push_back(mk_cfg(REG_NUM_TERMS, 32'h2));
		tab.push_back(mk_cfg(REG_COEF_0, 32'h0));
		tab.push_back(mk_cfg(REG_COEF_1, 32'hFFFF_0000));
		tab.push_back(mk_smp(32'h0000_8000, 32'h0, 1'b1, 32'hFFFF_8000, 32'h0000_8000));
		tab.push_back(mk_cfg(REG_COEF_1, 32'h0000_8000));
		tab.push_back(mk_smp(32'h1, 32'h0, 1'b1, 32'h1, 32'hFFFF_FFFF));
		tab.push_back(mk_cfg(REG_COEF_1, 32'hFFFF_8000));
		tab.push_back(mk_smp(32'h1, 32'h0, 1'b1, '0, '0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (j = 0; j < tab.size(); j++) begin
			if (tab[j].is_cfg) begin
				drain();
				write_reg(tab[j].addr, tab[j].a);
			end else begin
				if (tab[j].known) begin
					r = eval_row_set(tab[j].a, tab[j].b, 1'b0);
					check_field("table poly_value", tab[j].poly, r.poly);
					check_field("table residual", tab[j].resid, r.resid);
				end
				send_sample(tab[j].a, tab[j].b);
			end
		end

		for (ph = 0; ph < 10; ph++) begin
			drain();
			nt = (ph == 0) ? 7 : (ph == 1) ? 1 : (ph == 2) ? 0 : $urandom_range(0, 7);
			write_reg(REG_NUM_TERMS, ($urandom & ~32'h7) | nt);
			for (i = 0; i < MAX_TERMS; i++)
				write_reg(reg_idx_t'(int'(REG_COEF_0) + i),
					(ph == 0) ? QMAX : (ph == 1) ? QMIN : rand_q());
			gaps_on = (ph % 4 != 1);
			if (ph == 3) begin
				gaps_on = 1'b0;
				hold_off_req = 1'b1;
			end
			for (i = 0; i < 24; i++) begin
				if (ph == 6 && i == 12)
					drain();
				send_sample(rand_q(), rand_q());
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && design_rows.size() == 0)
			$display("[polynomial_eval_with_design_row_unit] OK");
		else
			$display("[polynomial_eval_with_design_row_unit] ERROR");
		$finish;
	end

endmodule
